/* design/sit_pkg.sv */
`default_nettype none
package sit_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W = 2 * DIFF_W;
	localparam int LEN_W = DIFF_W;
	localparam int UNIT_FRAC = 30;
	localparam int UNIT_W = UNIT_FRAC + 2;
	localparam int UQ_W = UNIT_FRAC + 1;
	localparam int PROD_W = 2 * UNIT_W;
	localparam int DMAG_W = UNIT_FRAC + 2;
	localparam int NUM_W = UNIT_W + DIFF_W;
	localparam int NMAG_W = NUM_W - 1;
	localparam int S_W = NMAG_W;
	localparam int DSQ_W = 64;
	localparam int EPS_DET_W = 30;
	localparam int EPS_POS_W = 16;
	localparam int OUT_W = 40;
	localparam int CFG_W = 64;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_MAX_DIST_SQ = 2'd0;
	localparam logic [IDX_W-1:0] REG_DET_EPS = 2'd1;
	localparam logic [IDX_W-1:0] REG_POS_EPS = 2'd2;

	localparam logic [DSQ_W-1:0] MAX_DIST_SQ_RST = '1;
	localparam logic [EPS_DET_W-1:0] DET_EPS_RST = EPS_DET_W'(1);
	localparam logic [EPS_POS_W-1:0] POS_EPS_RST = EPS_POS_W'(1);

	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = QPTR_W + 1;
	localparam int FLIGHT_W = 2;

	localparam int SQRT_LAT = LEN_W;
	localparam int UDIV_LAT = UQ_W + 1;
	localparam int QDIV_LAT = NMAG_W;

	// Quotient magnitudes above 2^62 are clamped; they always fail the range test.
	localparam logic [NMAG_W-1:0] QUOT_LIM = {2'b01, {(NMAG_W-2){1'b0}}};

	typedef struct packed {
		logic far;
		logic signed [DIFF_W-1:0] abx;
		logic signed [DIFF_W-1:0] aby;
		logic signed [DIFF_W-1:0] cdx;
		logic signed [DIFF_W-1:0] cdy;
		logic signed [DIFF_W-1:0] acx;
		logic signed [DIFF_W-1:0] acy;
	} sit_item_t;

	function automatic logic [DIFF_W-1:0] mag_of(input logic signed [DIFF_W-1:0] x);
		return x[DIFF_W-1] ? DIFF_W'(-x) : DIFF_W'(x);
	endfunction

endpackage
`default_nettype wire

/* design/sit_front.sv */
`default_nettype none
module sit_front import sit_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic signed [COORD_W-1:0]  ax,
	input  logic signed [COORD_W-1:0]  ay,
	input  logic signed [COORD_W-1:0]  bx,
	input  logic signed [COORD_W-1:0]  by,
	input  logic signed [COORD_W-1:0]  cx,
	input  logic signed [COORD_W-1:0]  cy,
	input  logic signed [COORD_W-1:0]  dx_end,
	input  logic signed [COORD_W-1:0]  dy_end,
	input  logic [DSQ_W-1:0]           max_dist_sq,
	output logic                       push,
	output sit_item_t                  push_item,
	output logic [FLIGHT_W-1:0]        in_flight
);

	logic valid_s1, valid_s2, valid_s3;
	sit_item_t item_s1, item_s2, item_s3;
	logic [SQ_W-1:0] sqx_s2, sqy_s2;
	logic [DIFF_W-1:0] mx, my;
	logic [SQ_W-1:0] dist_sum;
	logic [DSQ_W-1:0] dist_sq;
	logic far;

	assign mx = mag_of(item_s1.acx);
	assign my = mag_of(item_s1.acy);

	// The squared distance saturates at the top of its 64-bit range.
	assign dist_sum = sqx_s2 + sqy_s2;
	assign dist_sq = (|dist_sum[SQ_W-1:DSQ_W]) ? '1 : dist_sum[DSQ_W-1:0];
	assign far = !(dist_sq < max_dist_sq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s1.far <= 1'b0;
		item_s1.abx <= {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
		item_s1.aby <= {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
		item_s1.cdx <= {dx_end[COORD_W-1], dx_end} - {cx[COORD_W-1], cx};
		item_s1.cdy <= {dy_end[COORD_W-1], dy_end} - {cy[COORD_W-1], cy};
		item_s1.acx <= {cx[COORD_W-1], cx} - {ax[COORD_W-1], ax};
		item_s1.acy <= {cy[COORD_W-1], cy} - {ay[COORD_W-1], ay};
		item_s2 <= item_s1;
		sqx_s2 <= SQ_W'(mx) * SQ_W'(mx);
		sqy_s2 <= SQ_W'(my) * SQ_W'(my);
		item_s3 <= '{far: far, abx: item_s2.abx, aby: item_s2.aby,
			cdx: item_s2.cdx, cdy: item_s2.cdy, acx: item_s2.acx, acy: item_s2.acy};
	end

	assign push = valid_s3;
	assign push_item = item_s3;
	assign in_flight = FLIGHT_W'(valid_s1) + FLIGHT_W'(valid_s2) + FLIGHT_W'(valid_s3);

endmodule
`default_nettype wire

/* design/sit_queue.sv */
`default_nettype none
module sit_queue import sit_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sit_item_t          push_item,
	input  logic               pop,
	output logic               out_valid,
	output sit_item_t          out_item,
	output logic [QCNT_W-1:0]  count
);

	sit_item_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic pop_ok;

	assign out_valid = (count_q != '0);
	assign out_item = mem_q[rd_ptr_q];
	assign pop_ok = pop && out_valid;
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop_ok) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop_ok && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* design/sit_sqrt.sv */
`default_nettype none
module sit_sqrt import sit_pkg::*; (
	input  logic              clk,
	input  logic [SQ_W-1:0]   rad,
	output logic [LEN_W-1:0]  root
);

	// One result bit per stage, two radicand bits brought down each time.
	logic [LEN_W:0] rem_q [SQRT_LAT];
	logic [LEN_W-1:0] root_q [SQRT_LAT];
	logic [SQ_W-1:0] rad_q [SQRT_LAT];

	logic [LEN_W:0] rem_in [SQRT_LAT];
	logic [LEN_W-1:0] root_in [SQRT_LAT];
	logic [SQ_W-1:0] rad_in [SQRT_LAT];
	logic [LEN_W+2:0] cur [SQRT_LAT];
	logic [LEN_W+2:0] trial [SQRT_LAT];
	logic [LEN_W:0] rem_d [SQRT_LAT];
	logic [LEN_W-1:0] root_d [SQRT_LAT];
	logic [SQ_W-1:0] rad_d [SQRT_LAT];

	always_comb begin
		for (int i = 0; i < SQRT_LAT; i++) begin
			if (i == 0) begin
				rem_in[i] = '0;
				root_in[i] = '0;
				rad_in[i] = rad;
			end else begin
				rem_in[i] = rem_q[i-1];
				root_in[i] = root_q[i-1];
				rad_in[i] = rad_q[i-1];
			end
			cur[i] = {rem_in[i], rad_in[i][SQ_W-1 -: 2]};
			trial[i] = {1'b0, root_in[i], 2'b01};
			if (cur[i] >= trial[i]) begin
				rem_d[i] = (LEN_W+1)'(cur[i] - trial[i]);
				root_d[i] = {root_in[i][LEN_W-2:0], 1'b1};
			end else begin
				rem_d[i] = cur[i][LEN_W:0];
				root_d[i] = {root_in[i][LEN_W-2:0], 1'b0};
			end
			rad_d[i] = {rad_in[i][SQ_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SQRT_LAT; i++) begin
			rem_q[i] <= rem_d[i];
			root_q[i] <= root_d[i];
			rad_q[i] <= rad_d[i];
		end
	end

	assign root = root_q[SQRT_LAT-1];

endmodule
`default_nettype wire

/* design/sit_udiv.sv */
`default_nettype none
module sit_udiv import sit_pkg::*; (
	input  logic                      clk,
	input  logic signed [DIFF_W-1:0]  comp,
	input  logic [LEN_W-1:0]          len,
	output logic signed [UNIT_W-1:0]  unit
);

	// Computes (|comp| << 30) / len. Since len >= |comp| the quotient fits
	// in 31 bits, so the first partial remainder is |comp| >> 1.
	logic [LEN_W-1:0] r_q [UQ_W];
	logic [UQ_W-1:0] q_q [UQ_W];
	logic [LEN_W-1:0] len_q [UQ_W];
	logic neg_q [UQ_W];
	logic nz_q [UQ_W];

	logic [LEN_W-1:0] r_in [UQ_W];
	logic [UQ_W-1:0] q_in [UQ_W];
	logic [LEN_W-1:0] len_in [UQ_W];
	logic neg_in [UQ_W];
	logic nz_in [UQ_W];
	logic [LEN_W:0] cur [UQ_W];
	logic [LEN_W-1:0] r_d [UQ_W];
	logic [UQ_W-1:0] q_d [UQ_W];
	logic [DIFF_W-1:0] m;
	logic [UNIT_W-1:0] q_ext;
	logic signed [UNIT_W-1:0] unit_q;

	assign m = mag_of(comp);

	always_comb begin
		for (int i = 0; i < UQ_W; i++) begin
			if (i == 0) begin
				r_in[i] = {1'b0, m[DIFF_W-1:1]};
				q_in[i] = '0;
				len_in[i] = len;
				neg_in[i] = comp[DIFF_W-1];
				nz_in[i] = (len != '0);
				cur[i] = {r_in[i], m[0]};
			end else begin
				r_in[i] = r_q[i-1];
				q_in[i] = q_q[i-1];
				len_in[i] = len_q[i-1];
				neg_in[i] = neg_q[i-1];
				nz_in[i] = nz_q[i-1];
				cur[i] = {r_in[i], 1'b0};
			end
			if (cur[i] >= {1'b0, len_in[i]}) begin
				r_d[i] = LEN_W'(cur[i] - {1'b0, len_in[i]});
				q_d[i] = {q_in[i][UQ_W-2:0], 1'b1};
			end else begin
				r_d[i] = cur[i][LEN_W-1:0];
				q_d[i] = {q_in[i][UQ_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < UQ_W; i++) begin
			r_q[i] <= r_d[i];
			q_q[i] <= q_d[i];
			len_q[i] <= len_in[i];
			neg_q[i] <= neg_in[i];
			nz_q[i] <= nz_in[i];
		end
	end

	assign q_ext = {1'b0, q_q[UQ_W-1]};

	// A zero-length segment has a zero direction.
	always_ff @(posedge clk) begin
		if (!nz_q[UQ_W-1]) begin
			unit_q <= '0;
		end else if (neg_q[UQ_W-1]) begin
			unit_q <= -q_ext;
		end else begin
			unit_q <= q_ext;
		end
	end

	assign unit = unit_q;

endmodule
`default_nettype wire

/* design/sit_qdiv.sv */
`default_nettype none
module sit_qdiv import sit_pkg::*; (
	input  logic                clk,
	input  logic [NMAG_W-1:0]   num,
	input  logic [DMAG_W-1:0]   den,
	output logic [NMAG_W-1:0]   quo
);

	// Restoring division, one quotient bit per stage, most significant first.
	logic [DMAG_W-1:0] r_q [QDIV_LAT];
	logic [NMAG_W-1:0] q_q [QDIV_LAT];
	logic [NMAG_W-1:0] n_q [QDIV_LAT];
	logic [DMAG_W-1:0] d_q [QDIV_LAT];

	logic [DMAG_W-1:0] r_in [QDIV_LAT];
	logic [NMAG_W-1:0] q_in [QDIV_LAT];
	logic [NMAG_W-1:0] n_in [QDIV_LAT];
	logic [DMAG_W-1:0] d_in [QDIV_LAT];
	logic [DMAG_W:0] cur [QDIV_LAT];
	logic [DMAG_W-1:0] r_d [QDIV_LAT];
	logic [NMAG_W-1:0] q_d [QDIV_LAT];

	always_comb begin
		for (int i = 0; i < QDIV_LAT; i++) begin
			if (i == 0) begin
				r_in[i] = '0;
				q_in[i] = '0;
				n_in[i] = num;
				d_in[i] = den;
			end else begin
				r_in[i] = r_q[i-1];
				q_in[i] = q_q[i-1];
				n_in[i] = n_q[i-1];
				d_in[i] = d_q[i-1];
			end
			cur[i] = {r_in[i], n_in[i][NMAG_W-1]};
			if (cur[i] >= {1'b0, d_in[i]}) begin
				r_d[i] = DMAG_W'(cur[i] - {1'b0, d_in[i]});
				q_d[i] = {q_in[i][NMAG_W-2:0], 1'b1};
			end else begin
				r_d[i] = cur[i][DMAG_W-1:0];
				q_d[i] = {q_in[i][NMAG_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDIV_LAT; i++) begin
			r_q[i] <= r_d[i];
			q_q[i] <= q_d[i];
			n_q[i] <= {n_in[i][NMAG_W-2:0], 1'b0};
			d_q[i] <= d_in[i];
		end
	end

	assign quo = q_q[QDIV_LAT-1];

endmodule
`default_nettype wire

/* design/sit_back.sv */
`default_nettype none
module sit_back import sit_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  sit_item_t                 in_item,
	input  logic [EPS_DET_W-1:0]      det_eps,
	input  logic [EPS_POS_W-1:0]      pos_eps,
	output logic                      done,
	output logic                      hit,
	output logic signed [OUT_W-1:0]   dist_s,
	output logic signed [OUT_W-1:0]   dist_t
);

	typedef struct packed {
		logic valid;
		sit_item_t item;
	} sq_side_t;

	typedef struct packed {
		logic valid;
		logic far;
		logic signed [DIFF_W-1:0] acx;
		logic signed [DIFF_W-1:0] acy;
		logic [LEN_W-1:0] nu;
		logic [LEN_W-1:0] nv;
	} ud_side_t;

	typedef struct packed {
		logic valid;
		logic kill;
		logic s_neg;
		logic t_neg;
		logic [LEN_W-1:0] nu;
		logic [LEN_W-1:0] nv;
	} qd_side_t;

	// Radicands for the two segment lengths.
	logic valid_s1, valid_s2, valid_s3;
	sit_item_t item_s1, item_s2, item_s3;
	logic [SQ_W-1:0] sq_abx_s2, sq_aby_s2, sq_cdx_s2, sq_cdy_s2;
	logic [SQ_W-1:0] rad_u_s3, rad_v_s3;
	logic [DIFF_W-1:0] m_abx, m_aby, m_cdx, m_cdy;

	assign m_abx = mag_of(item_s1.abx);
	assign m_aby = mag_of(item_s1.aby);
	assign m_cdx = mag_of(item_s1.cdx);
	assign m_cdy = mag_of(item_s1.cdy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		item_s2 <= item_s1;
		sq_abx_s2 <= SQ_W'(m_abx) * SQ_W'(m_abx);
		sq_aby_s2 <= SQ_W'(m_aby) * SQ_W'(m_aby);
		sq_cdx_s2 <= SQ_W'(m_cdx) * SQ_W'(m_cdx);
		sq_cdy_s2 <= SQ_W'(m_cdy) * SQ_W'(m_cdy);
		item_s3 <= item_s2;
		rad_u_s3 <= sq_abx_s2 + sq_aby_s2;
		rad_v_s3 <= sq_cdx_s2 + sq_cdy_s2;
	end

	// Segment lengths.
	logic [LEN_W-1:0] nu, nv;
	sq_side_t sq_dl_q [SQRT_LAT];
	sq_side_t sq_out;

	sit_sqrt u_sqrt_u (.clk(clk), .rad(rad_u_s3), .root(nu));
	sit_sqrt u_sqrt_v (.clk(clk), .rad(rad_v_s3), .root(nv));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SQRT_LAT; i++) begin
				sq_dl_q[i] <= '0;
			end
		end else begin
			sq_dl_q[0] <= '{valid: valid_s3, item: item_s3};
			for (int i = 1; i < SQRT_LAT; i++) begin
				sq_dl_q[i] <= sq_dl_q[i-1];
			end
		end
	end

	assign sq_out = sq_dl_q[SQRT_LAT-1];

	// Unit directions.
	logic signed [UNIT_W-1:0] ux, uy, vx, vy;
	ud_side_t ud_dl_q [UDIV_LAT];
	ud_side_t ud_out;

	sit_udiv u_div_ux (.clk(clk), .comp(sq_out.item.abx), .len(nu), .unit(ux));
	sit_udiv u_div_uy (.clk(clk), .comp(sq_out.item.aby), .len(nu), .unit(uy));
	sit_udiv u_div_vx (.clk(clk), .comp(sq_out.item.cdx), .len(nv), .unit(vx));
	sit_udiv u_div_vy (.clk(clk), .comp(sq_out.item.cdy), .len(nv), .unit(vy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < UDIV_LAT; i++) begin
				ud_dl_q[i] <= '0;
			end
		end else begin
			ud_dl_q[0] <= '{valid: sq_out.valid, far: sq_out.item.far,
				acx: sq_out.item.acx, acy: sq_out.item.acy, nu: nu, nv: nv};
			for (int i = 1; i < UDIV_LAT; i++) begin
				ud_dl_q[i] <= ud_dl_q[i-1];
			end
		end
	end

	assign ud_out = ud_dl_q[UDIV_LAT-1];

	// Cross products for the determinant and both numerators.
	logic valid_s4, far_s4;
	logic [LEN_W-1:0] nu_s4, nv_s4;
	logic signed [PROD_W-1:0] p_vxuy_s4, p_vyux_s4;
	logic signed [NUM_W-1:0] ns_a_s4, ns_b_s4, nt_a_s4, nt_b_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= ud_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		far_s4 <= ud_out.far;
		nu_s4 <= ud_out.nu;
		nv_s4 <= ud_out.nv;
		p_vxuy_s4 <= PROD_W'(vx) * PROD_W'(uy);
		p_vyux_s4 <= PROD_W'(vy) * PROD_W'(ux);
		ns_a_s4 <= NUM_W'(vx) * NUM_W'(ud_out.acy);
		ns_b_s4 <= NUM_W'(vy) * NUM_W'(ud_out.acx);
		nt_a_s4 <= NUM_W'(ux) * NUM_W'(ud_out.acy);
		nt_b_s4 <= NUM_W'(uy) * NUM_W'(ud_out.acx);
	end

	// Determinant magnitude, parallel test and numerator magnitudes.
	logic signed [PROD_W-1:0] det;
	logic [PROD_W-1:0] det_abs;
	logic signed [NUM_W-1:0] num_s, num_t;
	logic [NUM_W-1:0] abs_s, abs_t;
	logic [DMAG_W-1:0] det_mag;
	logic parallel;

	assign det = p_vxuy_s4 - p_vyux_s4;
	assign det_abs = det[PROD_W-1] ? -det : det;
	assign det_mag = det_abs[UNIT_FRAC +: DMAG_W];
	assign parallel = (det_mag <= DMAG_W'(det_eps));
	assign num_s = ns_a_s4 - ns_b_s4;
	assign num_t = nt_a_s4 - nt_b_s4;
	assign abs_s = num_s[NUM_W-1] ? -num_s : num_s;
	assign abs_t = num_t[NUM_W-1] ? -num_t : num_t;

	logic valid_s5, kill_s5, s_neg_s5, t_neg_s5;
	logic [LEN_W-1:0] nu_s5, nv_s5;
	logic [NMAG_W-1:0] mag_s_s5, mag_t_s5;
	logic [DMAG_W-1:0] det_mag_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		kill_s5 <= far_s4 || parallel;
		s_neg_s5 <= num_s[NUM_W-1] ^ det[PROD_W-1];
		t_neg_s5 <= num_t[NUM_W-1] ^ det[PROD_W-1];
		nu_s5 <= nu_s4;
		nv_s5 <= nv_s4;
		mag_s_s5 <= abs_s[NMAG_W-1:0];
		mag_t_s5 <= abs_t[NMAG_W-1:0];
		det_mag_s5 <= det_mag;
	end

	// Quotients s and t.
	logic [NMAG_W-1:0] quo_s, quo_t;
	qd_side_t qd_dl_q [QDIV_LAT];
	qd_side_t qd_out;

	sit_qdiv u_div_s (.clk(clk), .num(mag_s_s5), .den(det_mag_s5), .quo(quo_s));
	sit_qdiv u_div_t (.clk(clk), .num(mag_t_s5), .den(det_mag_s5), .quo(quo_t));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QDIV_LAT; i++) begin
				qd_dl_q[i] <= '0;
			end
		end else begin
			qd_dl_q[0] <= '{valid: valid_s5, kill: kill_s5, s_neg: s_neg_s5,
				t_neg: t_neg_s5, nu: nu_s5, nv: nv_s5};
			for (int i = 1; i < QDIV_LAT; i++) begin
				qd_dl_q[i] <= qd_dl_q[i-1];
			end
		end
	end

	assign qd_out = qd_dl_q[QDIV_LAT-1];

	// Clamp and apply signs.
	logic [NMAG_W-1:0] lim_s, lim_t;
	logic valid_s6, kill_s6;
	logic [LEN_W-1:0] nu_s6, nv_s6;
	logic signed [S_W-1:0] s_s6, t_s6;

	assign lim_s = (quo_s > QUOT_LIM) ? QUOT_LIM : quo_s;
	assign lim_t = (quo_t > QUOT_LIM) ? QUOT_LIM : quo_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= qd_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		kill_s6 <= qd_out.kill;
		nu_s6 <= qd_out.nu;
		nv_s6 <= qd_out.nv;
		s_s6 <= qd_out.s_neg ? -lim_s : lim_s;
		t_s6 <= qd_out.t_neg ? -lim_t : lim_t;
	end

	// Range test. A hit keeps s and t well inside the output width.
	logic signed [S_W-1:0] pe, lo, s_hi, t_hi;
	logic in_range;

	assign pe = S_W'(pos_eps);
	assign lo = -pe;
	assign s_hi = S_W'(nu_s6) + pe;
	assign t_hi = S_W'(nv_s6) + pe;
	assign in_range = !kill_s6 && (s_s6 >= lo) && (s_s6 < s_hi)
		&& (t_s6 >= lo) && (t_s6 < t_hi);

	logic done_s7, hit_s7;
	logic signed [OUT_W-1:0] dist_s_s7, dist_t_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s7 <= 1'b0;
			hit_s7 <= 1'b0;
		end else begin
			done_s7 <= valid_s6;
			hit_s7 <= valid_s6 && in_range;
		end
	end

	always_ff @(posedge clk) begin
		dist_s_s7 <= in_range ? s_s6[OUT_W-1:0] : '0;
		dist_t_s7 <= in_range ? t_s6[OUT_W-1:0] : '0;
	end

	assign done = done_s7;
	assign hit = hit_s7;
	assign dist_s = dist_s_s7;
	assign dist_t = dist_t_s7;

endmodule
`default_nettype wire

/* design/segment_intersection_test.sv */
// Throughput: one transaction per cycle while busy is low; the two pipelined square roots, the four
// unit dividers and the two 64-stage quotient dividers each start a new item every cycle.
// The receiver cannot stall, so busy stays low in normal operation.
// Reset (arst_n low, asynchronous) empties the pipeline and queue and loads the
// register defaults.
`default_nettype none
module segment_intersection_test import sit_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] ax,
	input  logic signed [COORD_W-1:0] ay,
	input  logic signed [COORD_W-1:0] bx,
	input  logic signed [COORD_W-1:0] by,
	input  logic signed [COORD_W-1:0] cx,
	input  logic signed [COORD_W-1:0] cy,
	input  logic signed [COORD_W-1:0] dx_end,
	input  logic signed [COORD_W-1:0] dy_end,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_index,
	input  logic [CFG_W-1:0]          wr_data,
	output logic                      done,
	output logic                      hit,
	output logic signed [OUT_W-1:0]   dist_s,
	output logic signed [OUT_W-1:0]   dist_t
);

	logic [DSQ_W-1:0] max_dist_sq_q;
	logic [EPS_DET_W-1:0] det_eps_q;
	logic [EPS_POS_W-1:0] pos_eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_sq_q <= MAX_DIST_SQ_RST;
			det_eps_q <= DET_EPS_RST;
			pos_eps_q <= POS_EPS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MAX_DIST_SQ: max_dist_sq_q <= wr_data[DSQ_W-1:0];
				REG_DET_EPS: det_eps_q <= wr_data[EPS_DET_W-1:0];
				REG_POS_EPS: pos_eps_q <= wr_data[EPS_POS_W-1:0];
				default: ;
			endcase
		end
	end

	logic take, push, q_valid;
	sit_item_t push_item, q_item;
	logic [FLIGHT_W-1:0] in_flight;
	logic [QCNT_W-1:0] q_count;
	logic [QCNT_W:0] occupancy;

	// Credit check: items in the front stages plus the queue never exceed its depth.
	assign occupancy = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(in_flight);
	assign busy = (occupancy >= (QCNT_W+1)'(QUEUE_DEPTH));
	assign take = start && !busy;

	sit_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take),
		.ax(ax), .ay(ay), .bx(bx), .by(by),
		.cx(cx), .cy(cy), .dx_end(dx_end), .dy_end(dy_end),
		.max_dist_sq(max_dist_sq_q),
		.push(push), .push_item(push_item), .in_flight(in_flight)
	);

	sit_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item),
		.pop(q_valid), .out_valid(q_valid), .out_item(q_item), .count(q_count)
	);

	sit_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_item(q_item),
		.det_eps(det_eps_q), .pos_eps(pos_eps_q),
		.done(done), .hit(hit), .dist_s(dist_s), .dist_t(dist_t)
	);

endmodule
`default_nettype wire
